@@ design/moesif_line_coherence_fsm_core_macros.svh @@
// assertion macros used by the core rtl file
`ifndef MOESIF_LINE_COHERENCE_FSM_CORE_MACROS_SVH
`define MOESIF_LINE_COHERENCE_FSM_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define MLC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, checked out of reset
`define MLC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MLC_ASSERT_NOW(lbl, ante, cons)
`define MLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/mlcfsm_pkg.sv @@
`default_nettype none

package mlcfsm_pkg;

   localparam int ADDR_WIDTH_DEF    = 32;
   localparam int NODE_ID_WIDTH_DEF = 4;
   localparam int OP_WIDTH          = 3;
   localparam int STATE_WIDTH       = 4;
   localparam int FLAG_COUNT        = 8;

   typedef logic [OP_WIDTH-1:0]    op_type;
   typedef logic [STATE_WIDTH-1:0] line_state_type;

   // transaction kinds
   localparam op_type OP_LOAD  = 3'd0;
   localparam op_type OP_STORE = 3'd1;
   localparam op_type OP_GETS  = 3'd2;
   localparam op_type OP_GETM  = 3'd3;
   localparam op_type OP_DATA  = 3'd4;

   // line states, stable then transient
   localparam line_state_type ST_I  = 4'd0;
   localparam line_state_type ST_S  = 4'd1;
   localparam line_state_type ST_E  = 4'd2;
   localparam line_state_type ST_O  = 4'd3;
   localparam line_state_type ST_M  = 4'd4;
   localparam line_state_type ST_F  = 4'd5;
   localparam line_state_type ST_IS = 4'd6;
   localparam line_state_type ST_IM = 4'd7;
   localparam line_state_type ST_SM = 4'd8;
   localparam line_state_type ST_OM = 4'd9;
   localparam line_state_type ST_FM = 4'd10;

   typedef struct packed {
      logic protocol_error;
      logic silent_upgrade_event;
      logic miss_event;
      logic assert_shared;
      logic data_to_processor;
      logic data_to_bus;
      logic issue_getm;
      logic issue_gets;
   } flags_type;

endpackage

`default_nettype wire

@@ design/moesif_line_coherence_fsm_core.sv @@
// an accepted transaction is held in the input register, then moves into the result
// register once the result side is free; rsp_tvalid is driven by the result register
// throughput: one transaction per cycle, sustained while rsp_tready stays high
// the line state register updates as each transaction moves into the result register
// an input register and a result register part the two sides, so req can be taken while
// a result waits; reset (synchronous) empties both and returns the line to invalid
`default_nettype none
`include "moesif_line_coherence_fsm_core_macros.svh"

module moesif_line_coherence_fsm_core
   import mlcfsm_pkg::*;
#(
   parameter int ADDR_WIDTH    = ADDR_WIDTH_DEF,
   parameter int NODE_ID_WIDTH = NODE_ID_WIDTH_DEF,
   localparam int REQ_WIDTH    = ((ADDR_WIDTH + NODE_ID_WIDTH + 1 + 7) / 8) * 8,
   localparam int RSP_WIDTH    =
      ((FLAG_COUNT + ADDR_WIDTH + NODE_ID_WIDTH + STATE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // line_addr, requester_id, shared_seen, zero fill
   input  wire logic [REQ_WIDTH-1:0] req_tdata,
   // op
   input  wire op_type               req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // issue_gets, issue_getm, data_to_bus, data_to_processor, assert_shared,
   // miss_event, silent_upgrade_event, protocol_error, out_addr, dest_node,
   // next_state, zero fill
   output logic [RSP_WIDTH-1:0]      rsp_tdata
);

   localparam int ADDR_LO  = FLAG_COUNT;
   localparam int DEST_LO  = ADDR_LO + ADDR_WIDTH;
   localparam int STATE_LO = DEST_LO + NODE_ID_WIDTH;

   // input register
   logic                     in_valid_ff, in_valid_in;
   op_type                   in_op_ff;
   logic [ADDR_WIDTH-1:0]    in_addr_ff;
   logic [NODE_ID_WIDTH-1:0] in_req_ff;
   logic                     in_shared_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   flags_type                rsp_flags_ff;
   logic [ADDR_WIDTH-1:0]    rsp_addr_ff;
   logic [NODE_ID_WIDTH-1:0] rsp_dest_ff;
   line_state_type           rsp_state_ff;

   line_state_type           state_ff, state_in;

   flags_type                x_flags;
   logic [ADDR_WIDTH-1:0]    x_addr;
   logic [NODE_ID_WIDTH-1:0] x_dest;
   line_state_type           x_next;

   logic out_free, move;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   mlcfsm_xfer #(
      .ADDR_WIDTH    (ADDR_WIDTH),
      .NODE_ID_WIDTH (NODE_ID_WIDTH)
   ) u_xfer (
      .op           (in_op_ff),
      .line_state   (state_ff),
      .line_addr    (in_addr_ff),
      .requester_id (in_req_ff),
      .shared_seen  (in_shared_ff),
      .flags        (x_flags),
      .out_addr     (x_addr),
      .dest_node    (x_dest),
      .next_state   (x_next)
   );

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      state_in     = move ? x_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_I;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff     <= req_tuser;
         in_addr_ff   <= req_tdata[ADDR_WIDTH-1:0];
         in_req_ff    <= req_tdata[ADDR_WIDTH +: NODE_ID_WIDTH];
         in_shared_ff <= req_tdata[ADDR_WIDTH + NODE_ID_WIDTH];
      end
      if (move) begin
         rsp_flags_ff <= x_flags;
         rsp_addr_ff  <= x_addr;
         rsp_dest_ff  <= x_dest;
         rsp_state_ff <= x_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                            = '0;
      rsp_tdata[0]                         = rsp_flags_ff.issue_gets;
      rsp_tdata[1]                         = rsp_flags_ff.issue_getm;
      rsp_tdata[2]                         = rsp_flags_ff.data_to_bus;
      rsp_tdata[3]                         = rsp_flags_ff.data_to_processor;
      rsp_tdata[4]                         = rsp_flags_ff.assert_shared;
      rsp_tdata[5]                         = rsp_flags_ff.miss_event;
      rsp_tdata[6]                         = rsp_flags_ff.silent_upgrade_event;
      rsp_tdata[7]                         = rsp_flags_ff.protocol_error;
      rsp_tdata[ADDR_LO +: ADDR_WIDTH]     = rsp_addr_ff;
      rsp_tdata[DEST_LO +: NODE_ID_WIDTH]  = rsp_dest_ff;
      rsp_tdata[STATE_LO +: STATE_WIDTH]   = rsp_state_ff;
   end

   // an illegal transaction leaves the line where it was
   `MLC_ASSERT_NEXT(a_err_keeps_state, move && x_flags.protocol_error, $stable(state_ff))
   // the reported next state is the one now held
   `MLC_ASSERT_NEXT(a_rsp_matches_state, move, rsp_state_ff == state_ff)
   // a held transaction is not dropped while the result side stalls
   `MLC_ASSERT_NEXT(a_hold_input, in_valid_ff && !out_free, in_valid_ff)
   // an error result carries no bus or processor action
   `MLC_ASSERT_NOW(a_err_quiet, rsp_valid_ff && rsp_flags_ff.protocol_error,
      !(rsp_flags_ff.issue_gets || rsp_flags_ff.issue_getm ||
        rsp_flags_ff.data_to_bus || rsp_flags_ff.data_to_processor))

endmodule

`default_nettype wire

@@ design/mlcfsm_xfer.sv @@
`default_nettype none

module mlcfsm_xfer
   import mlcfsm_pkg::*;
#(
   parameter int ADDR_WIDTH    = ADDR_WIDTH_DEF,
   parameter int NODE_ID_WIDTH = NODE_ID_WIDTH_DEF
) (
   input  wire op_type                   op,
   input  wire line_state_type           line_state,
   input  wire logic [ADDR_WIDTH-1:0]    line_addr,
   input  wire logic [NODE_ID_WIDTH-1:0] requester_id,
   input  wire logic                     shared_seen,
   output flags_type                     flags,
   output logic [ADDR_WIDTH-1:0]         out_addr,
   output logic [NODE_ID_WIDTH-1:0]      dest_node,
   output line_state_type                next_state
);

   flags_type      f;
   line_state_type nx;
   logic           store;

   always_comb begin
      f     = '0;
      nx    = line_state;
      store = (op == OP_STORE);
      case (op)
         OP_LOAD, OP_STORE: begin
            case (line_state)
               ST_I: begin
                  f.miss_event = 1'b1;
                  if (store) begin
                     f.issue_getm = 1'b1;
                     nx           = ST_IM;
                  end else begin
                     f.issue_gets = 1'b1;
                     nx           = ST_IS;
                  end
               end
               ST_S, ST_O, ST_F: begin
                  if (store) begin
                     f.issue_getm = 1'b1;
                     f.miss_event = 1'b1;
                     if (line_state == ST_S) begin
                        nx = ST_SM;
                     end else if (line_state == ST_O) begin
                        nx = ST_OM;
                     end else begin
                        nx = ST_FM;
                     end
                  end else begin
                     f.data_to_processor = 1'b1;
                  end
               end
               ST_E: begin
                  f.data_to_processor = 1'b1;
                  if (store) begin
                     nx                     = ST_M;
                     f.silent_upgrade_event = 1'b1;
                  end
               end
               ST_M: begin
                  f.data_to_processor = 1'b1;
               end
               // processor access while a bus request is outstanding
               default: begin
                  f.protocol_error = 1'b1;
               end
            endcase
         end
         OP_GETS, OP_GETM, OP_DATA: begin
            case (line_state)
               ST_I: begin
               end
               ST_S: begin
                  if (op == OP_GETM) begin
                     nx = ST_I;
                  end else begin
                     f.assert_shared = 1'b1;
                  end
               end
               ST_E, ST_M: begin
                  if (op == OP_GETS) begin
                     f.data_to_bus   = 1'b1;
                     f.assert_shared = 1'b1;
                     nx              = (line_state == ST_E) ? ST_F : ST_O;
                  end else if (op == OP_GETM) begin
                     f.data_to_bus = 1'b1;
                     nx            = ST_I;
                  end else begin
                     f.protocol_error = 1'b1;
                  end
               end
               ST_O, ST_F: begin
                  if (op == OP_GETS) begin
                     f.data_to_bus   = 1'b1;
                     f.assert_shared = 1'b1;
                  end else if (op == OP_GETM) begin
                     f.data_to_bus = 1'b1;
                     nx            = ST_I;
                  end else begin
                     f.assert_shared = 1'b1;
                  end
               end
               ST_IM: begin
                  if (op == OP_DATA) begin
                     f.data_to_processor = 1'b1;
                     nx                  = ST_M;
                  end
               end
               ST_IS: begin
                  if (op == OP_DATA) begin
                     f.data_to_processor = 1'b1;
                     nx                  = shared_seen ? ST_S : ST_E;
                  end
               end
               // a snooped getm leaves sm untouched
               ST_SM: begin
                  if (op == OP_GETS) begin
                     f.assert_shared = 1'b1;
                  end else if (op == OP_DATA) begin
                     f.data_to_processor = 1'b1;
                     nx                  = ST_M;
                  end
               end
               ST_OM, ST_FM: begin
                  if (op == OP_GETS) begin
                     f.data_to_bus   = 1'b1;
                     f.assert_shared = 1'b1;
                  end else if (op == OP_GETM) begin
                     f.data_to_bus = 1'b1;
                     nx            = ST_IM;
                  end else begin
                     f.data_to_processor = 1'b1;
                     nx                  = ST_M;
                  end
               end
               default: begin
                  f.protocol_error = 1'b1;
               end
            endcase
         end
         default: begin
            f.protocol_error = 1'b1;
         end
      endcase
      if (f.protocol_error) begin
         f  = '0;
         f.protocol_error = 1'b1;
         nx = line_state;
      end
   end

   assign flags      = f;
   assign next_state = nx;
   assign out_addr   = (f.issue_gets || f.issue_getm || f.data_to_bus || f.data_to_processor)
                       ? line_addr : '0;
   assign dest_node  = f.data_to_bus ? requester_id : '0;

endmodule

`default_nettype wire
